@@ hdl/m3i_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_pkg: shared types and constants for the 3x3 matrix inverse
// Transaction payload structs, datapath widths and cofactor index tables.
// ----------------------------------------------------------------------------
package m3i_pkg;

  // One input transaction: a 3x3 matrix of signed Q16.16 elements.
  typedef struct packed {
    logic signed [31:0] a00;
    logic signed [31:0] a01;
    logic signed [31:0] a02;
    logic signed [31:0] a10;
    logic signed [31:0] a11;
    logic signed [31:0] a12;
    logic signed [31:0] a20;
    logic signed [31:0] a21;
    logic signed [31:0] a22;
  } in_t;

  // One result transaction: inverse, determinant and flags.
  typedef struct packed {
    logic signed [31:0] inv00;
    logic signed [31:0] inv01;
    logic signed [31:0] inv02;
    logic signed [31:0] inv10;
    logic signed [31:0] inv11;
    logic signed [31:0] inv12;
    logic signed [31:0] inv20;
    logic signed [31:0] inv21;
    logic signed [31:0] inv22;
    logic signed [31:0] det_out;
    logic               singular;
    logic               overflow;
  } out_t;

  // Datapath widths.
  localparam int ELEM_W = 32;             // Q16.16 element
  localparam int PROD_W = 2 * ELEM_W;     // element product, Q32.32
  localparam int ADJ_W  = PROD_W + 1;     // cofactor difference
  localparam int DET_W  = 98;             // exact determinant, Q50.48
  localparam int NUM_W  = ADJ_W + ELEM_W; // |adj| scaled by 2^32
  localparam int QUO_W  = 33;             // quotient bits kept before saturation
  localparam int SH_W   = DET_W + QUO_W;  // widest shifted divisor

  // Divider register stages: range check, one stage per quotient bit, saturation.
  localparam int DIV_LAT  = QUO_W + 2;
  // Input to output register count.
  localparam int PIPE_LAT = 6 + DIV_LAT + 1;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // Cofactor k = m[PA]*m[PB] - m[NA]*m[NB], matrix stored row major.
  localparam int ADJ_PA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int ADJ_PB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int ADJ_NA [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int ADJ_NB [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
  // Cofactors used for the row 0 expansion of the determinant.
  localparam int DET_IDX [3] = '{0, 3, 6};

endpackage

@@ hdl/m3i_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_div: pipelined restoring divider with signed saturation
// Divides a magnitude by a magnitude one quotient bit per stage and returns
// the signed 32-bit saturated quotient with an overflow flag.
// ----------------------------------------------------------------------------
module m3i_div (
  input  logic                         clk_i,
  input  logic [m3i_pkg::NUM_W-1:0]    num_i,
  input  logic [m3i_pkg::DET_W-1:0]    den_i,
  input  logic                         neg_i,
  output logic [31:0]                  quo_o,
  output logic                         ovf_o
);

  localparam int NW = m3i_pkg::NUM_W;
  localparam int DW = m3i_pkg::DET_W;
  localparam int QW = m3i_pkg::QUO_W;
  localparam int SW = m3i_pkg::SH_W;

  logic [NW-1:0] r_q   [QW+1];
  logic [DW-1:0] d_q   [QW+1];
  logic [QW-1:0] q_q   [QW+1];
  logic          ovf_q [QW+1];
  logic          neg_q [QW+1];

  // Range check: a quotient of 2^33 or more saturates in any case.
  always_ff @(posedge clk_i) begin
    r_q[0]   <= num_i;
    d_q[0]   <= den_i;
    q_q[0]   <= '0;
    neg_q[0] <= neg_i;
    ovf_q[0] <= SW'(num_i) >= {den_i, {QW{1'b0}}};
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 1; s <= QW; s++) begin : g_step
    localparam int K = QW - s;
    logic [SW-1:0] sh_d;
    logic          ge_d;
    logic [QW-1:0] q_d;

    always_comb begin
      sh_d   = SW'(d_q[s-1]) << K;
      ge_d   = SW'(r_q[s-1]) >= sh_d;
      q_d    = q_q[s-1];
      q_d[K] = ge_d;
    end

    always_ff @(posedge clk_i) begin
      r_q[s]   <= ge_d ? (r_q[s-1] - sh_d[NW-1:0]) : r_q[s-1];
      d_q[s]   <= d_q[s-1];
      q_q[s]   <= q_d;
      ovf_q[s] <= ovf_q[s-1];
      neg_q[s] <= neg_q[s-1];
    end
  end

  // Saturate to the signed 32-bit range; exactly -2^31 is representable.
  always_ff @(posedge clk_i) begin
    if (!neg_q[QW]) begin
      if (ovf_q[QW] || q_q[QW] > QW'(m3i_pkg::SAT_POS)) begin
        quo_o <= m3i_pkg::SAT_POS;
        ovf_o <= 1'b1;
      end else begin
        quo_o <= q_q[QW][31:0];
        ovf_o <= 1'b0;
      end
    end else begin
      if (ovf_q[QW] || q_q[QW] > QW'(m3i_pkg::SAT_NEG)) begin
        quo_o <= m3i_pkg::SAT_NEG;
        ovf_o <= 1'b1;
      end else begin
        quo_o <= 32'(-q_q[QW][31:0]);
        ovf_o <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/matrix3x3_inverse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse: 3x3 matrix inverse by the adjugate, signed Q16.16
// Exact cofactors and determinant, inverse entries by pipelined division.
// ----------------------------------------------------------------------------
// A new matrix is taken on every clock cycle and busy never rises. Each
// transaction yields one result on result_o, flagged by done_o for a single
// cycle. Most of the pipeline lies in the nine parallel restoring dividers;
// six stages before them form the products, cofactors and determinant, and
// one output register follows.
// Results cannot be held off and must be captured when done_o is high.
module matrix3x3_inverse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  m3i_pkg::in_t  item_i,
  output logic          done_o,
  output m3i_pkg::out_t result_o
);

  localparam int EW = m3i_pkg::ELEM_W;
  localparam int PW = m3i_pkg::PROD_W;
  localparam int AW = m3i_pkg::ADJ_W;
  localparam int DW = m3i_pkg::DET_W;
  localparam int NW = m3i_pkg::NUM_W;
  localparam int DL = m3i_pkg::DIV_LAT;

  logic signed [EW-1:0] m_d [9];
  logic                 accept_d;

  assign busy     = 1'b0;
  assign accept_d = start && !busy;

  assign m_d[0] = item_i.a00;
  assign m_d[1] = item_i.a01;
  assign m_d[2] = item_i.a02;
  assign m_d[3] = item_i.a10;
  assign m_d[4] = item_i.a11;
  assign m_d[5] = item_i.a12;
  assign m_d[6] = item_i.a20;
  assign m_d[7] = item_i.a21;
  assign m_d[8] = item_i.a22;

  // Valid bits that travel alongside the first six stages.
  logic [5:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], accept_d};
    end
  end

  // Stage 1: the eighteen element products.
  logic signed [PW-1:0] pp_q [9];
  logic signed [PW-1:0] pn_q [9];
  logic signed [EW-1:0] row1_q [3];
  logic signed [EW-1:0] row2_q [3];

  for (genvar k = 0; k < 9; k++) begin : g_prod
    always_ff @(posedge clk_i) begin
      pp_q[k] <= m_d[m3i_pkg::ADJ_PA[k]] * m_d[m3i_pkg::ADJ_PB[k]];
      pn_q[k] <= m_d[m3i_pkg::ADJ_NA[k]] * m_d[m3i_pkg::ADJ_NB[k]];
    end
  end

  // Stage 2: cofactor differences.
  logic signed [AW-1:0] adj2_q [9];
  logic signed [AW-1:0] adj3_q [9];
  logic signed [AW-1:0] adj4_q [9];
  logic signed [AW-1:0] adj5_q [9];

  for (genvar k = 0; k < 9; k++) begin : g_adj
    always_ff @(posedge clk_i) begin
      adj2_q[k] <= {pp_q[k][PW-1], pp_q[k]} - {pn_q[k][PW-1], pn_q[k]};
      adj3_q[k] <= adj2_q[k];
      adj4_q[k] <= adj3_q[k];
      adj5_q[k] <= adj4_q[k];
    end
  end

  // Top row carried to the determinant stage.
  for (genvar j = 0; j < 3; j++) begin : g_row
    always_ff @(posedge clk_i) begin
      row1_q[j] <= m_d[j];
      row2_q[j] <= row1_q[j];
    end
  end

  // Stage 3: row 0 expansion products, cofactor split in two halves.
  logic signed [AW-1:0] plo_q [3];
  logic signed [AW-1:0] phi_q [3];

  for (genvar j = 0; j < 3; j++) begin : g_dprod
    always_ff @(posedge clk_i) begin
      plo_q[j] <= row2_q[j] * $signed({1'b0, adj2_q[m3i_pkg::DET_IDX[j]][EW-1:0]});
      phi_q[j] <= row2_q[j] * $signed(adj2_q[m3i_pkg::DET_IDX[j]][AW-1:EW]);
    end
  end

  // Stage 4: recombine the halves of each expansion term.
  logic signed [DW-1:0] term_q [3];

  for (genvar j = 0; j < 3; j++) begin : g_term
    always_ff @(posedge clk_i) begin
      term_q[j] <= {phi_q[j][AW-1], phi_q[j], {EW{1'b0}}}
                 + {{(DW-AW){plo_q[j][AW-1]}}, plo_q[j]};
    end
  end

  // Stage 5: exact determinant.
  logic signed [DW-1:0] det_q;

  always_ff @(posedge clk_i) begin
    det_q <= term_q[0] + term_q[1] + term_q[2];
  end

  // Stage 6: magnitudes and signs for the dividers, determinant output.
  logic [NW-1:0]      num_q [9];
  logic               neg_q [9];
  logic [DW-1:0]      den_q;
  logic [31:0]        dout_q;
  logic               dovf_q;
  logic               sing_q;
  logic [DW-1:0]      dmag_d;
  logic [DW-EW-1:0]   dsh_d;

  always_comb begin
    dmag_d = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
    dsh_d  = dmag_d[DW-1:EW];
  end

  for (genvar k = 0; k < 9; k++) begin : g_mag
    always_ff @(posedge clk_i) begin
      num_q[k] <= {(adj5_q[k][AW-1] ? AW'(-adj5_q[k]) : AW'(adj5_q[k])), {EW{1'b0}}};
      neg_q[k] <= adj5_q[k][AW-1] ^ det_q[DW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    den_q  <= dmag_d;
    sing_q <= (det_q == '0);
    if (!det_q[DW-1]) begin
      dovf_q <= dsh_d > (DW-EW)'(m3i_pkg::SAT_POS);
      dout_q <= (dsh_d > (DW-EW)'(m3i_pkg::SAT_POS)) ? m3i_pkg::SAT_POS : dsh_d[31:0];
    end else begin
      dovf_q <= dsh_d > (DW-EW)'(m3i_pkg::SAT_NEG);
      dout_q <= (dsh_d > (DW-EW)'(m3i_pkg::SAT_NEG)) ? m3i_pkg::SAT_NEG
                                                      : 32'(-dsh_d[31:0]);
    end
  end

  // Nine dividers, one per inverse entry.
  logic [31:0] quo_d [9];
  logic [8:0]  qovf_d;

  for (genvar k = 0; k < 9; k++) begin : g_div
    m3i_div u_div (
      .clk_i (clk_i),
      .num_i (num_q[k]),
      .den_i (den_q),
      .neg_i (neg_q[k]),
      .quo_o (quo_d[k]),
      .ovf_o (qovf_d[k])
    );
  end

  // Determinant side band delayed to line up with the dividers.
  logic [31:0] ddl_q  [DL];
  logic        dodl_q [DL];
  logic        sdl_q  [DL];
  logic [DL-1:0] vdl_q;

  always_ff @(posedge clk_i) begin
    ddl_q[0]  <= dout_q;
    dodl_q[0] <= dovf_q;
    sdl_q[0]  <= sing_q;
    for (int i = 1; i < DL; i++) begin
      ddl_q[i]  <= ddl_q[i-1];
      dodl_q[i] <= dodl_q[i-1];
      sdl_q[i]  <= sdl_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vdl_q <= '0;
    end else begin
      vdl_q <= {vdl_q[DL-2:0], vld_q[5]};
    end
  end

  // Output register: a singular matrix gives a zero inverse and no overflow.
  m3i_pkg::out_t res_q;
  logic          done_q;
  logic          sing_d;

  assign sing_d = sdl_q[DL-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vdl_q[DL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.inv00    <= sing_d ? '0 : quo_d[0];
    res_q.inv01    <= sing_d ? '0 : quo_d[1];
    res_q.inv02    <= sing_d ? '0 : quo_d[2];
    res_q.inv10    <= sing_d ? '0 : quo_d[3];
    res_q.inv11    <= sing_d ? '0 : quo_d[4];
    res_q.inv12    <= sing_d ? '0 : quo_d[5];
    res_q.inv20    <= sing_d ? '0 : quo_d[6];
    res_q.inv21    <= sing_d ? '0 : quo_d[7];
    res_q.inv22    <= sing_d ? '0 : quo_d[8];
    res_q.det_out  <= ddl_q[DL-1];
    res_q.singular <= sing_d;
    res_q.overflow <= !sing_d && (dodl_q[DL-1] || (|qovf_d));
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

@@ hdl/m3i_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_chk: port level checks for the 3x3 matrix inverse
// Watches latency and the result flags, bound to the top level.
// ----------------------------------------------------------------------------
module m3i_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input m3i_pkg::out_t result_o
);

  // Every accepted transaction gives a result after the fixed latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(m3i_pkg::PIPE_LAT) done_o)
    else $error("result missing after accepted transaction");

  // No result appears without a matching earlier transaction.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, m3i_pkg::PIPE_LAT))
    else $error("result without transaction");

  // A singular result carries a zero determinant and zero inv00, inv01, inv11, inv12, inv22.
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.singular) |->
      (result_o.inv00 == 0 && result_o.inv11 == 0 && result_o.inv22 == 0 &&
       result_o.inv01 == 0 && result_o.inv12 == 0 && result_o.det_out == 0))
    else $error("singular result with nonzero entries");

  // Overflow and singular never come together.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(result_o.singular && result_o.overflow))
    else $error("singular and overflow both set");

endmodule

bind matrix3x3_inverse m3i_chk u_m3i_chk (.*);
